@@ rtl/bline_pkg.sv @@
// ----------------------------------------------------------------------------
// bline_pkg
// Shared types and constants of the Bresenham line blending engine.
// ----------------------------------------------------------------------------
package bline_pkg;

  localparam int COORD_BITS = 12;
  localparam int ADDR_BITS  = 24;
  localparam int PITCH_BITS = 13;
  localparam int PIXEL_BITS = 16;
  // Decision term and increments span roughly -2*max .. +2*max.
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(640);
  localparam logic [PIXEL_BITS-1:0] MASK_RESET  = PIXEL_BITS'(16'hF7DE);

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_PITCH = 1'b0,
    REG_MASK  = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    STATUS_OK   = 1'b0,
    STATUS_IDLE = 1'b1
  } status_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    cmd_t                  cmd;
    logic [ADDR_BITS-1:0]  row_base;
    logic [COORD_BITS-1:0] x0;
    logic                  x_major;
    logic                  x_pos;
    logic                  y_pos;
    logic [COORD_BITS-1:0] maj;
    logic [COORD_BITS-1:0] mnr;
    logic [PIXEL_BITS-1:0] color;
    logic [PIXEL_BITS-1:0] old_pixel;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

@@ rtl/bline_front.sv @@
// ----------------------------------------------------------------------------
// bline_front
// Input stage: takes words, works out the line geometry and the row base.
// ----------------------------------------------------------------------------
module bline_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [bline_pkg::COORD_BITS-1:0] x_start,
  input  logic [bline_pkg::COORD_BITS-1:0] y_start,
  input  logic [bline_pkg::COORD_BITS-1:0] x_end,
  input  logic [bline_pkg::COORD_BITS-1:0] y_end,
  input  logic [bline_pkg::PIXEL_BITS-1:0] line_color,
  input  logic [bline_pkg::PIXEL_BITS-1:0] old_pixel,
  input  logic [bline_pkg::PITCH_BITS-1:0] pitch,
  input  logic [bline_pkg::PIXEL_BITS-1:0] mask,
  input  bline_pkg::queue_stat_t           q_stat,
  output logic                             push,
  output bline_pkg::entry_t                push_entry
);
  import bline_pkg::*;

  logic   stage_valid;
  entry_t stage;
  entry_t stage_next;

  logic [COORD_BITS-1:0]            adx;
  logic [COORD_BITS-1:0]            ady;
  logic [COORD_BITS+PITCH_BITS-1:0] product;

  assign push     = stage_valid && !q_stat.full;
  assign in_ready = !stage_valid || !q_stat.full;

  always_comb begin
    adx     = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
    ady     = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
    product = (COORD_BITS+PITCH_BITS)'(y_start) * (COORD_BITS+PITCH_BITS)'(pitch);

    stage_next.cmd       = cmd_t'(cmd);
    stage_next.row_base  = ADDR_BITS'(product);
    stage_next.x0        = x_start;
    stage_next.x_major   = adx > ady;
    stage_next.x_pos     = x_end > x_start;
    stage_next.y_pos     = y_end > y_start;
    stage_next.maj       = (adx > ady) ? adx : ady;
    stage_next.mnr       = (adx > ady) ? ady : adx;
    // The colour keeps the mask that is in force when the line starts.
    stage_next.color     = line_color & mask;
    stage_next.old_pixel = old_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= stage_next;
    end
  end

  assign push_entry = stage;

endmodule

@@ rtl/bline_queue.sv @@
// ----------------------------------------------------------------------------
// bline_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module bline_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bline_pkg::entry_t      push_entry,
  input  logic                   pop,
  output bline_pkg::entry_t      pop_entry,
  output bline_pkg::queue_stat_t q_stat
);
  import bline_pkg::*;

  entry_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign q_stat.full  = count == QUEUE_CNT_BITS'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;
  assign pop_entry    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ rtl/bline_back.sv @@
// ----------------------------------------------------------------------------
// bline_back
// Line stepper and blender: holds the running line and registers results.
// ----------------------------------------------------------------------------
module bline_back (
  input  logic                             clk,
  input  logic                             rst,
  input  bline_pkg::queue_stat_t           q_stat,
  input  bline_pkg::entry_t                pop_entry,
  output logic                             pop,
  input  logic [bline_pkg::PITCH_BITS-1:0] pitch,
  input  logic [bline_pkg::PIXEL_BITS-1:0] mask,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             write_valid,
  output logic [bline_pkg::ADDR_BITS-1:0]  write_addr,
  output logic [bline_pkg::PIXEL_BITS-1:0] write_data,
  output logic                             read_valid,
  output logic [bline_pkg::ADDR_BITS-1:0]  read_addr,
  output logic                             last,
  output logic                             status
);
  import bline_pkg::*;

  // Line state.
  logic                        active;
  logic [ADDR_BITS-1:0]        cur_addr;
  logic signed [DEC_BITS-1:0]  decision;
  logic signed [DEC_BITS-1:0]  straight_inc;
  logic signed [DEC_BITS-1:0]  diagonal_inc;
  logic [ADDR_BITS-1:0]        major_step;
  logic [ADDR_BITS-1:0]        minor_step;
  logic [COORD_BITS-1:0]       pixels_left;
  logic [PIXEL_BITS-1:0]       masked_color;

  logic                        active_next;
  logic [ADDR_BITS-1:0]        cur_addr_next;
  logic signed [DEC_BITS-1:0]  decision_next;
  logic signed [DEC_BITS-1:0]  straight_inc_next;
  logic signed [DEC_BITS-1:0]  diagonal_inc_next;
  logic [ADDR_BITS-1:0]        major_step_next;
  logic [ADDR_BITS-1:0]        minor_step_next;
  logic [COORD_BITS-1:0]       pixels_left_next;
  logic [PIXEL_BITS-1:0]       masked_color_next;

  // Result registers.
  logic                  write_valid_next;
  logic [ADDR_BITS-1:0]  write_addr_next;
  logic [PIXEL_BITS-1:0] write_data_next;
  logic                  read_valid_next;
  logic [ADDR_BITS-1:0]  read_addr_next;
  logic                  last_next;
  status_t               status_next;

  logic [ADDR_BITS-1:0]   pitch_a;
  logic [ADDR_BITS-1:0]   x_step;
  logic [ADDR_BITS-1:0]   y_step;
  logic [ADDR_BITS-1:0]   start_addr;
  logic [DEC_BITS-1:0]    maj_w;
  logic [DEC_BITS-1:0]    mnr_w;
  logic [PIXEL_BITS:0]    blend_sum;
  logic                   go_straight;

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_comb begin
    pitch_a     = ADDR_BITS'(pitch);
    x_step      = pop_entry.x_pos ? ADDR_BITS'(1) : '1;
    y_step      = pop_entry.y_pos ? pitch_a : (ADDR_BITS'(0) - pitch_a);
    start_addr  = pop_entry.row_base + ADDR_BITS'(pop_entry.x0);
    maj_w       = DEC_BITS'(pop_entry.maj);
    mnr_w       = DEC_BITS'(pop_entry.mnr);
    blend_sum   = (PIXEL_BITS+1)'(pop_entry.old_pixel & mask) + (PIXEL_BITS+1)'(masked_color);
    go_straight = decision[DEC_BITS-1] || (decision == '0);

    active_next       = active;
    cur_addr_next     = cur_addr;
    decision_next     = decision;
    straight_inc_next = straight_inc;
    diagonal_inc_next = diagonal_inc;
    major_step_next   = major_step;
    minor_step_next   = minor_step;
    pixels_left_next  = pixels_left;
    masked_color_next = masked_color;

    write_valid_next = 1'b0;
    write_addr_next  = '0;
    write_data_next  = '0;
    read_valid_next  = 1'b0;
    read_addr_next   = '0;
    last_next        = 1'b0;
    status_next      = STATUS_OK;

    unique case (pop_entry.cmd)
      CMD_START: begin
        // A start drops any running line.
        active_next       = 1'b1;
        cur_addr_next     = start_addr;
        decision_next     = signed'((mnr_w << 1) - maj_w);
        straight_inc_next = signed'(mnr_w << 1);
        diagonal_inc_next = signed'((mnr_w - maj_w) << 1);
        major_step_next   = pop_entry.x_major ? x_step : y_step;
        minor_step_next   = pop_entry.x_major ? y_step : x_step;
        pixels_left_next  = pop_entry.maj;
        masked_color_next = pop_entry.color;
        read_valid_next   = 1'b1;
        read_addr_next    = start_addr;
      end
      CMD_PIXEL: begin
        if (!active) begin
          status_next = STATUS_IDLE;
        end else begin
          write_valid_next = 1'b1;
          write_addr_next  = cur_addr;
          write_data_next  = blend_sum[PIXEL_BITS:1];
          if (pixels_left == '0) begin
            active_next = 1'b0;
            last_next   = 1'b1;
          end else begin
            if (go_straight) begin
              decision_next = decision + straight_inc;
              cur_addr_next = cur_addr + major_step;
            end else begin
              decision_next = decision + diagonal_inc;
              cur_addr_next = cur_addr + minor_step + major_step;
            end
            pixels_left_next = pixels_left - COORD_BITS'(1);
            read_valid_next  = 1'b1;
            read_addr_next   = cur_addr_next;
          end
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active    <= active_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr     <= cur_addr_next;
      decision     <= decision_next;
      straight_inc <= straight_inc_next;
      diagonal_inc <= diagonal_inc_next;
      major_step   <= major_step_next;
      minor_step   <= minor_step_next;
      pixels_left  <= pixels_left_next;
      masked_color <= masked_color_next;
      write_valid  <= write_valid_next;
      write_addr   <= write_addr_next;
      write_data   <= write_data_next;
      read_valid   <= read_valid_next;
      read_addr    <= read_addr_next;
      last         <= last_next;
      status       <= status_next;
    end
  end

endmodule

@@ rtl/bresenham_line_blend_core.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_blend_core
// Bresenham line engine that blends a colour 50/50 into a 16-bit framebuffer.
// ----------------------------------------------------------------------------
// A start word (cmd 0) sets up a line and returns the first read address; each
// pixel word (cmd 1) carries the old pixel at the last read address and returns
// one blended write plus the next read address (on the final pixel, last and no
// read; with no line running, idle status). Every word gives exactly one result
// word, and one word per cycle is sustained while out_ready is high: the front
// register holds the row-base multiply, and the back stage does one Bresenham
// step per word with a 24-bit three-input address add and a 15-bit decision add.
// A two-entry queue parts the two halves; the result register takes a new word
// only once the previous result is taken. Registers are written through
// cfg_write, cfg_index and cfg_data, only while the block is idle: the user, not the core, sees to it.
// ----------------------------------------------------------------------------
module bresenham_line_blend_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [bline_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [bline_pkg::COORD_BITS-1:0]    x_start,
  input  logic [bline_pkg::COORD_BITS-1:0]    y_start,
  input  logic [bline_pkg::COORD_BITS-1:0]    x_end,
  input  logic [bline_pkg::COORD_BITS-1:0]    y_end,
  input  logic [bline_pkg::PIXEL_BITS-1:0]    line_color,
  input  logic [bline_pkg::PIXEL_BITS-1:0]    old_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                write_valid,
  output logic [bline_pkg::ADDR_BITS-1:0]     write_addr,
  output logic [bline_pkg::PIXEL_BITS-1:0]    write_data,
  output logic                                read_valid,
  output logic [bline_pkg::ADDR_BITS-1:0]     read_addr,
  output logic                                last,
  output logic                                status
);
  import bline_pkg::*;

  logic [PITCH_BITS-1:0] pitch_pixels;
  logic [PIXEL_BITS-1:0] blend_mask;

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_pixels <= PITCH_RESET;
      blend_mask   <= MASK_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_PITCH: pitch_pixels <= PITCH_BITS'(cfg_data);
        REG_MASK:  blend_mask   <= PIXEL_BITS'(cfg_data);
        default:   blend_mask   <= blend_mask;
      endcase
    end
  end

  bline_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .line_color (line_color),
    .old_pixel  (old_pixel),
    .pitch      (pitch_pixels),
    .mask       (blend_mask),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  bline_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  bline_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .pitch       (pitch_pixels),
    .mask        (blend_mask),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_valid (write_valid),
    .write_addr  (write_addr),
    .write_data  (write_data),
    .read_valid  (read_valid),
    .read_addr   (read_addr),
    .last        (last),
    .status      (status)
  );

endmodule

@@ tb/sv/bresenham_line_blend_core_tb.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_blend_core_tb
// Self-checking bench for the Bresenham line blending engine.
// ----------------------------------------------------------------------------
// Start and pixel words are driven through the input handshake, and a
// line tracer in the bench follows every accepted word to work out the
// blended write and the next read address that the block must return.
// The results are compared field by field as they leave the output
// handshake, in order. Directed lines cover several octants, ties, single
// points, restarts and idle pixel words. The register test walks the
// pitch and mask through their extremes, with a mask change part way
// along a line. A long random run follows with bursty input and an
// output side that stalls on its own schedule.
// ----------------------------------------------------------------------------
module bresenham_line_blend_core_tb;
  import bline_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 500;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int PIXEL_MAX    = (1 << PIXEL_BITS) - 1;

  typedef struct packed {
    cmd_t                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [PIXEL_BITS-1:0] line_color;
    logic [PIXEL_BITS-1:0] old_pixel;
  } line_word_t;

  typedef struct packed {
    logic                  write_valid;
    logic [ADDR_BITS-1:0]  write_addr;
    logic [PIXEL_BITS-1:0] write_data;
    logic                  read_valid;
    logic [ADDR_BITS-1:0]  read_addr;
    logic                  last;
    status_t               status;
  } blend_result_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_LIGHT,
    FLOW_COMB,
    FLOW_HEAVY
  } flow_mode_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     cfg_write  = 1'b0;
  logic                     cfg_index  = 1'b0;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic                     cmd        = 1'b0;
  logic [COORD_BITS-1:0]    x_start    = '0;
  logic [COORD_BITS-1:0]    y_start    = '0;
  logic [COORD_BITS-1:0]    x_end      = '0;
  logic [COORD_BITS-1:0]    y_end      = '0;
  logic [PIXEL_BITS-1:0]    line_color = '0;
  logic [PIXEL_BITS-1:0]    old_pixel  = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic                     write_valid;
  logic [ADDR_BITS-1:0]     write_addr;
  logic [PIXEL_BITS-1:0]    write_data;
  logic                     read_valid;
  logic [ADDR_BITS-1:0]     read_addr;
  logic                     last;
  logic                     status;

  // Line tracer state, kept in step with the accepted words.
  logic [PITCH_BITS-1:0] pitch_reg    = PITCH_RESET;
  logic [PIXEL_BITS-1:0] mask_reg     = MASK_RESET;
  bit                    line_on      = 1'b0;
  logic [ADDR_BITS-1:0]  pix_addr     = '0;
  int                    err_term     = 0;
  int                    err_straight = 0;
  int                    err_diag     = 0;
  logic [ADDR_BITS-1:0]  step_major   = '0;
  logic [ADDR_BITS-1:0]  step_minor   = '0;
  int                    pixels_to_go = 0;
  logic [PIXEL_BITS-1:0] color_masked = '0;

  blend_result_t expected_blends[$];
  int            words_sent     = 0;
  int            words_accepted = 0;
  int            mismatches     = 0;
  int            cycles         = 0;
  bit            bursty         = 1'b1;
  int            burst_left     = 0;
  flow_mode_t    flow_mode      = FLOW_FREE;
  int            flow_left      = 0;
  int            flow_tick      = 0;

  bresenham_line_blend_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .line_color (line_color),
    .old_pixel  (old_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .write_valid(write_valid),
    .write_addr (write_addr),
    .write_data (write_data),
    .read_valid (read_valid),
    .read_addr  (read_addr),
    .last       (last),
    .status     (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("ERROR at %0t: %s is %0h, expected %0h", $realtime, what, got_v, want_v);
    mismatches++;
  endtask

  // Follows one accepted word through the line set-up or one Bresenham step.
  task automatic trace_line_word(input line_word_t w, output blend_result_t r);
    int x0, y0, x1, y1, adx, ady, span_major, span_minor;
    logic [ADDR_BITS-1:0] x_step, y_step;
    logic [31:0] origin;
    logic [PIXEL_BITS:0] sum;
    r = '0;
    if (w.cmd == CMD_START) begin
      x0 = w.x_start;
      y0 = w.y_start;
      x1 = w.x_end;
      y1 = w.y_end;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      x_step = (x1 > x0) ? ADDR_BITS'(1) : '1;
      y_step = (y1 > y0) ? ADDR_BITS'(pitch_reg) : ADDR_BITS'(0) - ADDR_BITS'(pitch_reg);
      // A tie in length makes y the major axis.
      if (adx > ady) begin
        step_major = x_step;
        step_minor = y_step;
        span_major = adx;
        span_minor = ady;
      end else begin
        step_major = y_step;
        step_minor = x_step;
        span_major = ady;
        span_minor = adx;
      end
      err_term     = 2 * span_minor - span_major;
      err_straight = 2 * span_minor;
      err_diag     = 2 * (span_minor - span_major);
      pixels_to_go = span_major;
      color_masked = w.line_color & mask_reg;
      origin       = 32'(y0) * 32'(pitch_reg) + 32'(x0);
      pix_addr     = origin[ADDR_BITS-1:0];
      line_on      = 1'b1;
      r.read_valid = 1'b1;
      r.read_addr  = pix_addr;
    end else if (!line_on) begin
      r.status = STATUS_IDLE;
    end else begin
      sum = {1'b0, w.old_pixel & mask_reg} + {1'b0, color_masked};
      r.write_valid = 1'b1;
      r.write_addr  = pix_addr;
      r.write_data  = sum[PIXEL_BITS:1];
      if (pixels_to_go == 0) begin
        line_on = 1'b0;
        r.last  = 1'b1;
      end else begin
        if (err_term <= 0) begin
          err_term += err_straight;
        end else begin
          err_term += err_diag;
          pix_addr += step_minor;
        end
        pix_addr += step_major;
        pixels_to_go--;
        r.read_valid = 1'b1;
        r.read_addr  = pix_addr;
      end
    end
  endtask

  // Results are checked before the word of the same edge is traced; a result
  // can never belong to a word accepted at the same edge.
  always @(posedge clk) begin
    blend_result_t got, want;
    line_word_t w;
    if (!rst && out_valid && out_ready) begin
      got.write_valid = write_valid;
      got.write_addr  = write_addr;
      got.write_data  = write_data;
      got.read_valid  = read_valid;
      got.read_addr   = read_addr;
      got.last        = last;
      got.status      = status_t'(status);
      if (expected_blends.size() == 0) begin
        report_mismatch("result word with none outstanding", got.read_addr, '0);
      end else begin
        want = expected_blends.pop_front();
        if (got.write_valid !== want.write_valid)
          report_mismatch("write_valid", got.write_valid, want.write_valid);
        if (got.write_addr !== want.write_addr)
          report_mismatch("write_addr", got.write_addr, want.write_addr);
        if (got.write_data !== want.write_data)
          report_mismatch("write_data", got.write_data, want.write_data);
        if (got.read_valid !== want.read_valid)
          report_mismatch("read_valid", got.read_valid, want.read_valid);
        if (got.read_addr !== want.read_addr)
          report_mismatch("read_addr", got.read_addr, want.read_addr);
        if (got.last !== want.last)
          report_mismatch("last", got.last, want.last);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
      end
    end
    if (!rst && in_valid && in_ready) begin
      w.cmd        = cmd_t'(cmd);
      w.x_start    = x_start;
      w.y_start    = y_start;
      w.x_end      = x_end;
      w.y_end      = y_end;
      w.line_color = line_color;
      w.old_pixel  = old_pixel;
      trace_line_word(w, want);
      expected_blends.push_back(want);
      words_accepted++;
    end
  end

  // The output side stalls in stretches, each with a pattern of its own.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_mode_t'($urandom_range(0, 3));
        flow_left = $urandom_range(16, 80);
      end
      flow_left--;
      flow_tick++;
      case (flow_mode)
        FLOW_FREE:  out_ready <= 1'b1;
        FLOW_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        FLOW_COMB:  out_ready <= (flow_tick % 5 != 0);
        default:    out_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input cmd_t c, input logic [COORD_BITS-1:0] xs, ys, xe, ye,
                           input logic [PIXEL_BITS-1:0] colour, old);
    int target;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (bursty) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    cmd        <= c;
    x_start    <= xs;
    y_start    <= ys;
    x_end      <= xe;
    y_end      <= ye;
    line_color <= colour;
    old_pixel  <= old;
    in_valid   <= 1'b1;
    words_sent++;
    target = words_sent;
    do @(negedge clk); while (words_accepted < target);
  endtask

  // Fields that a pixel word does not use are filled with noise.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] old);
    send_word(CMD_PIXEL, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
              $urandom_range(0, PIXEL_MAX), old);
  endtask

  task automatic draw_line(input int xs, ys, xe, ye, input logic [PIXEL_BITS-1:0] colour,
                           input int pixels);
    send_word(CMD_START, xs, ys, xe, ye, colour, $urandom_range(0, PIXEL_MAX));
    repeat (pixels) send_pixel($urandom_range(0, PIXEL_MAX));
  endtask

  function automatic int major_span(input int xs, ys, xe, ye);
    int adx, ady;
    adx = (xe > xs) ? xe - xs : xs - xe;
    ady = (ye > ys) ? ye - ys : ys - ye;
    return (adx > ady) ? adx : ady;
  endfunction

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_blends.size() != 0) @(negedge clk);
  endtask

  // Only ever called with the pipeline empty.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_write <= 1'b1;
    if (idx == REG_PITCH) pitch_reg = value[PITCH_BITS-1:0];
    else mask_reg = value[PIXEL_BITS-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_pitch();
    case ($urandom_range(0, 5))
      0:       return 16'd640;
      1:       return 16'd1;
      2:       return 16'd4096;
      3:       return 16'd0;
      4:       return $urandom_range(0, 65535);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return MASK_RESET;
      1:       return 16'h0000;
      2:       return 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  function automatic int nudge(input int c, input int reach);
    int d;
    d = $urandom_range(0, reach);
    if ($urandom_range(0, 1) && c + d <= COORD_MAX) return c + d;
    if (c >= d) return c - d;
    return c + d;
  endfunction

  task automatic test_directed_cases();
    // A pixel word with no line running gets idle status.
    send_pixel(16'hFFFF);
    // Single point: the first write is already the last one.
    send_word(CMD_START, 0, 0, 0, 0, 16'hFFFF, 16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    // Equal lengths make y the major axis.
    draw_line(0, 0, 3, 3, 16'h0000, 4);
    // x major, both steps negative, from the far corner.
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 16'hFFFF, 3);
    // y major going up the screen with x rising.
    draw_line(10, 20, 11, 16, 16'h1234, 5);
    // A new start drops the running line.
    send_word(CMD_START, 100, 100, 110, 105, 16'hA5A5, 16'h0000);
    send_pixel(16'hFFFF);
    send_word(CMD_START, COORD_MAX, 0, COORD_MAX, 1, 16'h5A5A, 16'hFFFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
  endtask

  task automatic test_register_extremes();
    wait_for_results();
    write_reg(REG_PITCH, 16'd0);
    write_reg(REG_MASK, 16'h0000);
    draw_line(5, 5, 8, 7, 16'hFFFF, 4);
    // Bits above the pitch width are dropped; the far corner wraps the address.
    wait_for_results();
    write_reg(REG_PITCH, 16'hFFFF);
    write_reg(REG_MASK, 16'hFFFF);
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 5, COORD_MAX - 2, 16'hFFFF, 6);
    draw_line(0, 3, 1, 0, 16'h8001, 4);
    wait_for_results();
    write_reg(REG_PITCH, 16'd1);
    write_reg(REG_MASK, 16'h0821);
    draw_line(2, 0, 0, 1, 16'h7FFE, 3);
    // Steps and colour are fixed at the start; only the old pixel sees the new mask.
    wait_for_results();
    write_reg(REG_PITCH, 16'd4096);
    write_reg(REG_MASK, MASK_RESET);
    draw_line(3, 3, 9, 6, 16'hFFFF, 3);
    wait_for_results();
    write_reg(REG_MASK, 16'h5555);
    write_reg(REG_PITCH, 16'd640);
    repeat (4) send_pixel($urandom_range(0, PIXEL_MAX));
    send_pixel(16'hFFFF);
  endtask

  task automatic test_random_lines();
    int xs, ys, xe, ye, span, cut, reach, phase_end, counted;
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      wait_for_results();
      write_reg(REG_PITCH, pick_pitch());
      write_reg(REG_MASK, pick_mask());
      bursty = ($urandom_range(0, 3) != 0);
      phase_end = counted + $urandom_range(30, 90);
      while (counted < phase_end && counted < RANDOM_WORDS) begin
        reach = ($urandom_range(0, 9) == 0) ? 40 : 10;
        xs = pick_coord();
        ys = pick_coord();
        xe = nudge(xs, reach);
        ye = nudge(ys, reach);
        span = major_span(xs, ys, xe, ye);
        case ($urandom_range(0, 19))
          0, 1: begin
            // Broken line: cut short and left for the next start to drop.
            cut = $urandom_range(0, span);
            draw_line(xs, ys, xe, ye, $urandom_range(0, PIXEL_MAX), cut);
            counted += cut + 1;
          end
          2: begin
            repeat ($urandom_range(1, 3))
              if (!line_on) send_pixel($urandom_range(0, PIXEL_MAX));
          end
          3: begin
            // Let the pipeline empty part way along, sometimes with a new mask.
            cut = $urandom_range(0, span);
            draw_line(xs, ys, xe, ye, $urandom_range(0, PIXEL_MAX), cut);
            wait_for_results();
            if ($urandom_range(0, 1)) write_reg(REG_MASK, pick_mask());
            repeat (span + 1 - cut) send_pixel($urandom_range(0, PIXEL_MAX));
            counted += span + 2;
          end
          default: begin
            draw_line(xs, ys, xe, ye, $urandom_range(0, PIXEL_MAX), span + 1);
            counted += span + 2;
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_random_lines();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
